FILE: src/assert_macros.svh
// Assertion macros used by the checker file of the frame verifier.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ADLR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("adlr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ADLR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("adlr assertion failed");

`endif

FILE: src/adlr_pkg.sv
// Package of the Adler-32 frame verifier: types, constants and status codes.
// Depends on nothing; the register, checksum, top-level and checker modules import it.
package adlr_pkg;

	// Adler-32 modulus, one bit wider than the sums so compares hold the carry.
	localparam logic [16:0] ADLER_MOD   = 17'd65521;
	// Header layout: eight identifier bytes, then four checksum bytes.
	localparam logic [3:0]  MAGIC_LEN   = 4'd8;
	localparam logic [3:0]  HEADER_LEN  = 4'd12;
	// Default identifier, byte zero in the lowest bits.
	localparam logic [63:0] MAGIC_RESET = 64'h0000_0002_5452_4742;
	// Starting values of the two sums.
	localparam logic [15:0] SUM_LOW_INIT  = 16'd1;
	localparam logic [15:0] SUM_HIGH_INIT = 16'd0;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_BAD_MAGIC = 2'd1,
		STATUS_MISMATCH  = 2'd2,
		STATUS_SHORT     = 2'd3
	} status_t;

	// One input word as held in the input register.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_word_t;

	// One result word.
	typedef struct packed {
		status_t     status;
		logic [31:0] computed_checksum;
		logic [31:0] header_checksum;
	} result_t;

endpackage

FILE: src/adlr_if.sv
// Valid/ready channel interfaces for the byte input and the result output.
// Depends on nothing outside this file.
interface adlr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface adlr_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] computed_checksum;
	logic [31:0] header_checksum;

	modport source (output valid, output status, output computed_checksum,
		output header_checksum, input ready);
	modport sink   (input valid, input status, input computed_checksum,
		input header_checksum, output ready);
endinterface

FILE: src/adlr_in_reg.sv
// Input register of the frame verifier: holds one accepted word until the
// checksum stage takes it. Depends on adlr_pkg.
module adlr_in_reg import adlr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  byte_word_t in_word,
	output logic       in_ready,
	input  logic       out_free,
	output logic       s1_valid,
	output byte_word_t s1_word,
	output logic       s1_advance
);

	logic       valid_s1;
	byte_word_t word_s1;

	// A plain byte always moves on; a last byte needs room in the result register.
	assign s1_advance = valid_s1 && (!word_s1.last_byte || out_free);
	assign in_ready   = !valid_s1 || s1_advance;
	assign s1_valid   = valid_s1;
	assign s1_word    = word_s1;

	// Valid flag of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload of the stage.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_word;
		end
	end

endmodule

FILE: src/adlr_check.sv
// Frame state and checksum stage: identifier compare, stored checksum capture,
// Adler-32 update and status decision on the last byte. Depends on adlr_pkg.
module adlr_check import adlr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [63:0] magic,
	input  logic        advance,
	input  byte_word_t  word,
	output logic        res_valid,
	output result_t     res
);

	logic [3:0]  pos_q;
	logic        magic_ok_q;
	logic [31:0] stored_q;
	logic [15:0] low_q;
	logic [15:0] high_q;

	logic [3:0]  pos_nx;
	logic        magic_ok_nx;
	logic [31:0] stored_nx;
	logic [15:0] low_nx;
	logic [15:0] high_nx;
	logic [16:0] low_sum;
	logic [16:0] high_sum;
	logic [7:0]  want_byte;
	logic [31:0] computed;

	// Per-byte update of the frame state.
	always_comb begin
		magic_ok_nx = magic_ok_q;
		stored_nx   = stored_q;
		low_nx      = low_q;
		high_nx     = high_q;
		want_byte   = magic[{pos_q[2:0], 3'b000} +: 8];
		low_sum     = {1'b0, low_q} + {9'd0, word.data_byte};
		high_sum    = 17'd0;
		if (pos_q < MAGIC_LEN) begin
			if (want_byte != word.data_byte) begin
				magic_ok_nx = 1'b0;
			end
		end else if (pos_q < HEADER_LEN) begin
			stored_nx[{pos_q[1:0], 3'b000} +: 8] = word.data_byte;
		end else begin
			low_nx   = (low_sum >= ADLER_MOD) ? 16'(low_sum - ADLER_MOD) : low_sum[15:0];
			high_sum = {1'b0, high_q} + {1'b0, low_nx};
			high_nx  = (high_sum >= ADLER_MOD) ? 16'(high_sum - ADLER_MOD) : high_sum[15:0];
		end
		pos_nx = (pos_q < HEADER_LEN) ? pos_q + 4'd1 : pos_q;
	end

	// Result of a frame, taken from the updated state.
	always_comb begin
		computed                = {high_nx, low_nx};
		res.computed_checksum   = computed;
		res.header_checksum     = stored_nx;
		priority if (pos_nx < HEADER_LEN) begin
			res.status = STATUS_SHORT;
		end else if (!magic_ok_nx) begin
			res.status = STATUS_BAD_MAGIC;
		end else if (computed != stored_nx) begin
			res.status = STATUS_MISMATCH;
		end else begin
			res.status = STATUS_OK;
		end
	end

	assign res_valid = advance && word.last_byte;

	// Frame state registers; a last byte returns them to their start values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= 4'd0;
			magic_ok_q <= 1'b1;
			stored_q   <= 32'd0;
			low_q      <= SUM_LOW_INIT;
			high_q     <= SUM_HIGH_INIT;
		end else if (advance) begin
			if (word.last_byte) begin
				pos_q      <= 4'd0;
				magic_ok_q <= 1'b1;
				stored_q   <= 32'd0;
				low_q      <= SUM_LOW_INIT;
				high_q     <= SUM_HIGH_INIT;
			end else begin
				pos_q      <= pos_nx;
				magic_ok_q <= magic_ok_nx;
				stored_q   <= stored_nx;
				low_q      <= low_nx;
				high_q     <= high_nx;
			end
		end
	end

endmodule

FILE: src/adlr_out_reg.sv
// Result register of the frame verifier: holds one result word until the
// receiver takes it. Depends on adlr_pkg.
module adlr_out_reg import adlr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t load_res,
	output logic    free,
	output logic    out_valid,
	output result_t out_res,
	input  logic    out_ready
);

	logic    valid_q;
	result_t res_q;

	// Room for a new result when empty or when the held one leaves this cycle.
	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	// Valid flag of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= load_res;
		end
	end

endmodule

FILE: src/adler32_frame_verifier_core.sv
// Top level of the Adler-32 frame verifier.
// Depends on adlr_pkg, adlr_if, adlr_in_reg, adlr_check and adlr_out_reg.
//
// Usage:
// in_ch carries the file image one word (byte) per handshake, with last_byte
// set on the final byte. out_ch carries one result word per file: status,
// the computed Adler-32 over bytes twelve onward, and the stored checksum
// from bytes eight to eleven. cfg_we with cfg_wdata loads the expected
// eight-byte identifier; write it only while no file is in flight.
// Throughput is one byte per cycle while no last byte waits for the result register:
// the input register feeds the checksum stage, whose two sums each need one add and one conditional subtract.
// A last byte is held in the input register, the checksum stage forms its result
// combinationally, and the result register then drives that result onto out_ch.
// Reset clears the frame state and the valid flags of both channel registers
// and loads the default identifier. When the receiver stalls, plain bytes keep
// flowing; a last byte waits in the input register until the result register
// frees, and in_ch.ready drops meanwhile.
module adler32_frame_verifier_core import adlr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	adlr_byte_if.sink   in_ch,
	adlr_result_if.source out_ch,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata
);

	logic [63:0] magic_q;
	byte_word_t  in_word;
	byte_word_t  s1_word;
	logic        s1_valid;
	logic        s1_advance;
	logic        out_free;
	logic        res_valid;
	result_t     res;
	result_t     out_res;
	logic        out_valid;

	// Expected identifier register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= MAGIC_RESET;
		end else if (cfg_we) begin
			magic_q <= cfg_wdata;
		end
	end

	assign in_word.data_byte = in_ch.data_byte;
	assign in_word.last_byte = in_ch.last_byte;

	adlr_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_word    (in_word),
		.in_ready   (in_ch.ready),
		.out_free   (out_free),
		.s1_valid   (s1_valid),
		.s1_word    (s1_word),
		.s1_advance (s1_advance)
	);

	adlr_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.magic     (magic_q),
		.advance   (s1_advance && s1_valid),
		.word      (s1_word),
		.res_valid (res_valid),
		.res       (res)
	);

	adlr_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.load_res  (res),
		.free      (out_free),
		.out_valid (out_valid),
		.out_res   (out_res),
		.out_ready (out_ch.ready)
	);

	// Drive the result channel.
	assign out_ch.valid             = out_valid;
	assign out_ch.status            = out_res.status;
	assign out_ch.computed_checksum = out_res.computed_checksum;
	assign out_ch.header_checksum   = out_res.header_checksum;

endmodule

FILE: src/adlr_checker.sv
// Port-level checker for the Adler-32 frame verifier, bound to the top level.
// Depends on adlr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module adlr_checker import adlr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [31:0] computed_checksum,
	input logic [31:0] header_checksum
);

	logic [65:0] out_payload;
	logic        stalled;

	assign out_payload = {status, computed_checksum, header_checksum};
	assign stalled     = out_valid && !out_ready;

	// A stalled result holds its word.
	`ADLR_ASSERT_NXT(a_out_hold, clk, arst_n, stalled, out_valid && $stable(out_payload))

	// An ok status means the two checksums agree.
	`ADLR_ASSERT_IMP(a_ok_match, clk, arst_n, out_valid && (status == STATUS_OK),
		computed_checksum == header_checksum)

	// A mismatch status means the two checksums differ.
	`ADLR_ASSERT_IMP(a_mismatch_differs, clk, arst_n, out_valid && (status == STATUS_MISMATCH),
		computed_checksum != header_checksum)

	// A result after an empty output comes from a word taken by the input register.
	`ADLR_ASSERT_IMP(a_result_source, clk, arst_n, $rose(out_valid),
		$past(in_valid && in_ready, 2))

endmodule

bind adler32_frame_verifier_core adlr_checker u_adlr_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in_ch.valid),
	.in_ready          (in_ch.ready),
	.out_valid         (out_ch.valid),
	.out_ready         (out_ch.ready),
	.status            (out_ch.status),
	.computed_checksum (out_ch.computed_checksum),
	.header_checksum   (out_ch.header_checksum)
);
